@@ src/hid_keyboard_report_builder_core_defines.svh @@
// assertion macros for the core rtl file
`ifndef HID_KEYBOARD_REPORT_BUILDER_CORE_DEFINES_SVH
`define HID_KEYBOARD_REPORT_BUILDER_CORE_DEFINES_SVH

`ifndef ASSERT_OFF

// property must hold at every edge out of reset
`define HKRB_ASSERT(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
        else $error("hkrb check failed");

// consequent must hold in the cycle after the antecedent
`define HKRB_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("hkrb check failed");

`else

`define HKRB_ASSERT(lbl, clk, rstn, expr)
`define HKRB_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

@@ src/hkrb_pkg.sv @@
package hkrb_pkg;

    // event kinds
    localparam logic [1:0] KIND_PRESS   = 2'd0;
    localparam logic [1:0] KIND_RELEASE = 2'd1;
    localparam logic [1:0] KIND_CLEAR   = 2'd2;

    // first modifier usage code
    localparam logic [7:0] MOD_BASE   = 8'hE0;
    localparam logic [4:0] MOD_PREFIX = MOD_BASE[7:3];

    // slot fields carried in one report
    localparam int OUT_SLOTS = 6;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] key_code;
    } event_t;

    typedef struct packed {
        logic [7:0] modifiers;
        logic [7:0] slot_0;
        logic [7:0] slot_1;
        logic [7:0] slot_2;
        logic [7:0] slot_3;
        logic [7:0] slot_4;
        logic [7:0] slot_5;
    } report_t;

    // broadcast control to every slot cell
    typedef struct packed {
        logic       en;
        logic       press;
        logic       release_key;
        logic       clear;
        logic [7:0] code;
    } cell_ctrl_t;

endpackage

@@ src/hkrb_slot_cell.sv @@
module hkrb_slot_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  hkrb_pkg::cell_ctrl_t ctrl,
    input  logic               done_in,
    output logic               done_out,
    input  logic               hit_in,
    output logic               hit_out,
    input  logic [7:0]         right_slot,
    output logic [7:0]         slot,
    output logic [7:0]         slot_next
);

    logic [7:0] slot_reg;
    logic       match;
    logic       empty;

    // compare against the broadcast code
    assign match = (slot_reg == ctrl.code);
    assign empty = (slot_reg == 8'd0);

    // press scan stops at a match or the first empty slot
    assign done_out = done_in | match | empty;
    // release: this slot and all later ones pull from the right
    assign hit_out  = hit_in | match;

    // next slot value
    always_comb
    begin
        slot_next = slot_reg;
        if (ctrl.clear)
        begin
            slot_next = 8'd0;
        end
        else if (ctrl.press && empty && !done_in)
        begin
            slot_next = ctrl.code;
        end
        else if (ctrl.release_key && (hit_in || match))
        begin
            slot_next = right_slot;
        end
    end

    // slot storage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg <= 8'd0;
        end
        else if (ctrl.en)
        begin
            slot_reg <= slot_next;
        end
    end

    assign slot = slot_reg;

endmodule

@@ src/hid_keyboard_report_builder_core.sv @@
// a report becomes valid in the cycle after its event item is accepted
// throughput: one item per cycle while reports are taken as they appear
// the slot cell chain settles press, release and compaction combinationally
// reset clears the modifier mask, every key slot and the report register
`include "hid_keyboard_report_builder_core_defines.svh"

module hid_keyboard_report_builder_core #(
    parameter int KEY_SLOTS = 6
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             event_valid,
    output logic             event_ready,
    input  hkrb_pkg::event_t event_item,
    output logic             report_valid,
    input  logic             report_ready,
    output hkrb_pkg::report_t report_item
);

    logic                 accept;
    logic                 code_is_key;
    logic                 code_is_mod;
    hkrb_pkg::cell_ctrl_t ctrl;
    logic [7:0]           mask_reg;
    logic [7:0]           mask_next;
    hkrb_pkg::report_t    report_reg;
    logic                 report_valid_reg;
    logic [7:0]           slot_cur  [KEY_SLOTS];
    logic [7:0]           slot_nxt  [KEY_SLOTS];
    logic [7:0]           right_val [KEY_SLOTS];
    logic                 done_c    [KEY_SLOTS+1];
    logic                 hit_c     [KEY_SLOTS+1];
    logic [7:0]           rpt_slot  [hkrb_pkg::OUT_SLOTS];
    logic [KEY_SLOTS-1:0] empty_vec;

    // handshake: output register frees up when taken
    assign event_ready = !report_valid_reg || report_ready;
    assign accept      = event_valid && event_ready;

    // decode the event
    assign code_is_key = (event_item.key_code != 8'd0) &&
                         (event_item.key_code < hkrb_pkg::MOD_BASE);
    assign code_is_mod = (event_item.key_code[7:3] == hkrb_pkg::MOD_PREFIX);

    assign ctrl.en          = accept;
    assign ctrl.press       = accept && code_is_key &&
                              (event_item.kind == hkrb_pkg::KIND_PRESS);
    assign ctrl.release_key = accept && code_is_key &&
                              (event_item.kind == hkrb_pkg::KIND_RELEASE);
    assign ctrl.clear       = accept && (event_item.kind == hkrb_pkg::KIND_CLEAR);
    assign ctrl.code        = event_item.key_code;

    // modifier mask next value
    always_comb
    begin
        mask_next = mask_reg;
        unique case (event_item.kind)
            hkrb_pkg::KIND_PRESS:
            begin
                if (code_is_mod)
                begin
                    mask_next[event_item.key_code[2:0]] = 1'b1;
                end
            end
            hkrb_pkg::KIND_RELEASE:
            begin
                if (code_is_mod)
                begin
                    mask_next[event_item.key_code[2:0]] = 1'b0;
                end
            end
            hkrb_pkg::KIND_CLEAR:
            begin
                mask_next = 8'd0;
            end
            default:
            begin
                mask_next = mask_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg <= 8'd0;
        end
        else if (accept)
        begin
            mask_reg <= mask_next;
        end
    end

    // chain ends
    assign done_c[0] = 1'b0;
    assign hit_c[0]  = 1'b0;

    // row of slot cells
    for (genvar i = 0; i < KEY_SLOTS; i++)
    begin : g_cell
        if (i == KEY_SLOTS - 1)
        begin : g_last
            assign right_val[i] = 8'd0;
        end
        else
        begin : g_mid
            assign right_val[i] = slot_cur[i+1];
        end

        hkrb_slot_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .done_in    (done_c[i]),
            .done_out   (done_c[i+1]),
            .hit_in     (hit_c[i]),
            .hit_out    (hit_c[i+1]),
            .right_slot (right_val[i]),
            .slot       (slot_cur[i]),
            .slot_next  (slot_nxt[i])
        );

        assign empty_vec[i] = (slot_cur[i] == 8'd0);
    end

    // report slot fields, zero past the last cell
    for (genvar j = 0; j < hkrb_pkg::OUT_SLOTS; j++)
    begin : g_rpt
        if (j < KEY_SLOTS)
        begin : g_used
            assign rpt_slot[j] = slot_nxt[j];
        end
        else
        begin : g_unused
            assign rpt_slot[j] = 8'd0;
        end
    end

    // report register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            report_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            report_valid_reg <= 1'b1;
        end
        else if (report_ready)
        begin
            report_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            report_reg <= '0;
        end
        else if (accept)
        begin
            report_reg.modifiers <= mask_next;
            report_reg.slot_0    <= rpt_slot[0];
            report_reg.slot_1    <= rpt_slot[1];
            report_reg.slot_2    <= rpt_slot[2];
            report_reg.slot_3    <= rpt_slot[3];
            report_reg.slot_4    <= rpt_slot[4];
            report_reg.slot_5    <= rpt_slot[5];
        end
    end

    assign report_valid = report_valid_reg;
    assign report_item  = report_reg;

    // checks
    `HKRB_ASSERT(a_slots_packed, clk, rst_n, (((empty_vec << 1) & ~empty_vec) == '0))
    `HKRB_ASSERT_NEXT(a_accept_gives_report, clk, rst_n, accept, report_valid_reg)
    `HKRB_ASSERT_NEXT(a_clear_empties, clk, rst_n, ctrl.clear, report_reg == '0)

endmodule
